FILE: src/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg
// Shared constants for the boundary-tag heap allocator: codes, block layout
// and the default arena size.
// ----------------------------------------------------------------------------
package bta_pkg;

   localparam int DEFAULT_HEAP_BYTES = 65536;

   localparam int ADDR_W = 48;
   localparam int SIZE_W = 17;
   localparam int WORD_W = 64;
   localparam int NEED_W = 18;

   localparam logic [WORD_W-1:0] HDR_BYTES = 64'd24;
   localparam logic [WORD_W-1:0] MIN_BLK   = 64'd48;
   localparam logic [WORD_W-1:0] LINK_BIT  = 64'h8000_0000_0000_0000;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_OOM  = 2'd1;
   localparam logic [1:0] STAT_NULL = 2'd2;
   localparam logic [1:0] STAT_BAD  = 2'd3;

endpackage

FILE: src/boundary_tag_heap_allocator.sv
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// First-fit boundary-tag allocator over an arena held in one word memory.
//
// Request items carry an action in req_tuser (allocate or free), a size and a
// user address in req_tdata. Every request item yields exactly one response
// item: the user address of the new block (zero for a free or a failed
// allocate) in rsp_tdata and a status code in rsp_tuser. heap_base is written
// through csr_wr_en / csr_wr_data; the user must write it only while idle,
// the block itself does not enforce it. One item is worked on at a time; the
// arena memory (one read and one write per cycle, registered read data) sets
// the rate. A null request or a rejected free address is answered straight
// from idle; an allocate reads the header of each free-list entry in turn and
// follows its link when it does not fit, then takes the block whole or splits
// it; a free checks the header and, if the next block is free, merges with it.
// The next request item is taken in the cycle after the response is loaded.
// After reset a clearing pass writes every arena word, laying down one free
// block over the whole arena; no request item is taken until it ends.
// A finished response waits in an output register; while the receiver
// stalls the block may take and work on the next request, and it
// holds that one's response until the register frees up.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator #(
   parameter int HEAP_BYTES = bta_pkg::DEFAULT_HEAP_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [71:0]                 req_tdata,   // request_size, block_address
   input  logic                        req_tuser,   // action
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [bta_pkg::ADDR_W-1:0]  rsp_tdata,   // address
   output logic [1:0]                  rsp_tuser,   // status
   input  logic                        csr_wr_en,
   input  logic [bta_pkg::ADDR_W-1:0]  csr_wr_data
);

   localparam int WORDS = HEAP_BYTES / 8;
   localparam int AW    = $clog2(WORDS);
   localparam int LIMIT = WORDS / 6 + 2;
   localparam int STW   = $clog2(LIMIT + 1);
   localparam int WW    = bta_pkg::WORD_W;
   localparam int NW    = bta_pkg::NEED_W;

   localparam logic [WW-1:0]  WORDS64 = WW'(WORDS);
   localparam logic [WW-1:0]  ARENA64 = WW'(WORDS) * 64'd8;
   localparam logic [AW-1:0]  LAST_W  = AW'(WORDS - 1);
   localparam logic [STW-1:0] LIMIT_S = STW'(LIMIT);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_A_HDR, S_A_NXT,
      S_R_P, S_R_N, S_R_W1, S_R_W2, S_R_W3, S_R_W4,
      S_A_S1, S_A_S2, S_A_S3, S_A_S4, S_A_S5, S_A_S6, S_A_W1, S_A_W2,
      S_F_HDR, S_F_PS1, S_F_PS2, S_F_NHDR, S_F_M1, S_F_M2,
      S_P1, S_P2, S_P3, S_RESP
   } state_type;

   state_type                  state_ff;
   logic [AW-1:0]              clr_ff;
   logic [bta_pkg::ADDR_W-1:0] base_ff;
   logic [AW-1:0]              head_ff;
   logic                       hv_ff;
   logic [NW-1:0]              need_ff;
   logic [AW-1:0]              cur_ff;
   logic [AW-1:0]              rm_ff;
   logic [AW-1:0]              psh_ff;
   logic                       caller_free_ff;
   logic [STW-1:0]             steps_ff;
   logic [WW-1:0]              blk_ff;
   logic [WW-1:0]              nsz_ff;
   logic [WW-1:0]              p_ff;
   logic [WW-1:0]              n_ff;
   logic [bta_pkg::ADDR_W-1:0] res_addr_ff;
   logic [1:0]                 res_stat_ff;
   logic                       rsp_tvalid_ff;
   logic [bta_pkg::ADDR_W-1:0] rsp_tdata_ff;
   logic [1:0]                 rsp_tuser_ff;
   logic                       rd_oob_ff;

   logic [WW-1:0]     mem_q;
   logic [WW-1:0]     rdata;
   logic              we;
   logic [WW-1:0]     wa;
   logic [WW-1:0]     wd;
   logic [WW-1:0]     ra;
   logic              mem_we;

   logic [WW-1:0]     cur64;
   logic [WW-1:0]     rm64;
   logic [WW-1:0]     psh64;
   logic [WW-1:0]     head64;
   logic [WW-1:0]     need64;
   logic [WW-1:0]     bsz;
   logic [WW-1:0]     left;
   logic [WW-1:0]     rest;
   logic [WW-1:0]     nxt;
   logic [WW-1:0]     msz;
   logic              fits;
   logic [NW-1:0]     need_c;
   logic [NW-1:0]     need_raw;
   logic [bta_pkg::SIZE_W-1:0] in_size;
   logic [bta_pkg::ADDR_W-1:0] in_addr;
   logic [bta_pkg::ADDR_W-1:0] off;
   logic [bta_pkg::ADDR_W-1:0] h48;
   logic [STW-1:0]    steps_n;
   logic [bta_pkg::ADDR_W-1:0] user_addr;

   function automatic logic size_ok(input logic [WW-1:0] i, input logic [WW-1:0] sz);
      return (sz[2:0] == 3'd0) && (sz >= bta_pkg::MIN_BLK) && (i < WORDS64) &&
             (sz <= ARENA64 - (i << 3));
   endfunction

   assign rdata   = rd_oob_ff ? '0 : mem_q;
   assign cur64   = WW'(cur_ff);
   assign rm64    = WW'(rm_ff);
   assign psh64   = WW'(psh_ff);
   assign head64  = WW'(head_ff);
   assign need64  = WW'(need_ff);
   assign bsz     = rdata & ~64'd1;
   assign fits    = bsz >= need64;
   assign left    = blk_ff - need64;
   assign rest    = cur64 + (need64 >> 3);
   assign nxt     = cur64 + (blk_ff >> 3);
   assign msz     = blk_ff + nsz_ff;
   assign steps_n = steps_ff + 1'b1;
   assign in_size = req_tdata[16:0];
   assign in_addr = req_tdata[64:17];
   assign need_raw = (NW'(in_size) + NW'(39)) & ~NW'(7);
   assign need_c  = (need_raw < NW'(48)) ? NW'(48) : need_raw;
   assign off     = in_addr - base_ff;
   assign h48     = (off - 48'd24) >> 3;
   assign user_addr = base_ff + bta_pkg::ADDR_W'(cur64 << 3) + 48'd24;

   always_comb begin
      we = 1'b0;
      wa = '0;
      wd = '0;
      ra = '0;
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            wa = WW'(clr_ff);
            wd = (clr_ff == '0 || clr_ff == LAST_W) ? ARENA64 : '0;
         end
         S_IDLE:  ra = (req_tuser == bta_pkg::ACT_FREE) ? WW'(h48) : head64;
         S_A_HDR: ra = fits ? cur64 + 64'd1 : cur64 + 64'd2;
         S_A_NXT: ra = rdata & ~bta_pkg::LINK_BIT;
         S_R_P:   ra = rm64 + 64'd2;
         S_R_W1: begin
            we = p_ff[63];
            wa = (p_ff & ~bta_pkg::LINK_BIT) + 64'd2;
            wd = n_ff;
         end
         S_R_W2: begin
            we = n_ff[63];
            wa = (n_ff & ~bta_pkg::LINK_BIT) + 64'd1;
            wd = p_ff;
         end
         S_R_W3: begin
            we = 1'b1;
            wa = rm64 + 64'd1;
         end
         S_R_W4: begin
            we = 1'b1;
            wa = rm64 + 64'd2;
         end
         S_A_S1: begin
            we = 1'b1;
            wa = cur64;
            wd = need64 | 64'd1;
         end
         S_A_S2: begin
            we = 1'b1;
            wa = cur64 + (need64 >> 3) - 64'd1;
            wd = need64 | 64'd1;
         end
         S_A_S3: begin
            we = 1'b1;
            wa = rest;
            wd = left;
         end
         S_A_S4: begin
            we = 1'b1;
            wa = rest + (left >> 3) - 64'd1;
            wd = left;
         end
         S_A_S5: begin
            we = 1'b1;
            wa = rest + 64'd1;
         end
         S_A_S6: begin
            we = 1'b1;
            wa = rest + 64'd2;
         end
         S_A_W1: begin
            we = 1'b1;
            wa = cur64;
            wd = blk_ff | 64'd1;
         end
         S_A_W2: begin
            we = 1'b1;
            wa = cur64 + (blk_ff >> 3) - 64'd1;
            wd = blk_ff | 64'd1;
         end
         S_F_PS1: begin
            we = 1'b1;
            wa = cur64;
            wd = blk_ff;
         end
         S_F_PS2: begin
            we = 1'b1;
            wa = nxt - 64'd1;
            wd = blk_ff;
            ra = nxt;
         end
         S_F_NHDR: ra = nxt + 64'd1;
         S_F_M1: begin
            we = 1'b1;
            wa = cur64;
            wd = msz;
         end
         S_F_M2: begin
            we = 1'b1;
            wa = cur64 + (msz >> 3) - 64'd1;
            wd = msz;
         end
         S_P1: begin
            we = 1'b1;
            wa = psh64 + 64'd2;
            wd = hv_ff ? (bta_pkg::LINK_BIT | head64) : '0;
         end
         S_P2: begin
            we = 1'b1;
            wa = psh64 + 64'd1;
         end
         S_P3: begin
            we = hv_ff;
            wa = head64 + 64'd1;
            wd = bta_pkg::LINK_BIT | psh64;
         end
         default: ;
      endcase
   end

   assign mem_we = we && (wa < WORDS64);

   bta_ram #(
      .WIDTH(WW),
      .DEPTH(WORDS)
   ) u_arena (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(wa[AW-1:0]),
      .wr_data(wd),
      .rd_addr(ra[AW-1:0]),
      .rd_data(mem_q)
   );

   always_ff @(posedge clock) begin
      rd_oob_ff <= ra >= WORDS64;
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         base_ff       <= '0;
         head_ff       <= '0;
         hv_ff         <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_RESP) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_W) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  res_addr_ff <= '0;
                  if (req_tuser == bta_pkg::ACT_ALLOC) begin
                     need_ff  <= need_c;
                     cur_ff   <= head_ff;
                     steps_ff <= '0;
                     if (in_size == '0) begin
                        res_stat_ff <= bta_pkg::STAT_NULL;
                        state_ff    <= S_RESP;
                     end else if (!hv_ff) begin
                        res_stat_ff <= bta_pkg::STAT_OOM;
                        state_ff    <= S_RESP;
                     end else begin
                        state_ff <= S_A_HDR;
                     end
                  end else begin
                     cur_ff <= h48[AW-1:0];
                     if (in_addr == '0) begin
                        res_stat_ff <= bta_pkg::STAT_NULL;
                        state_ff    <= S_RESP;
                     end else if (off < 48'd24 || off[2:0] != 3'd0 ||
                                  WW'(h48) >= WORDS64) begin
                        res_stat_ff <= bta_pkg::STAT_BAD;
                        state_ff    <= S_RESP;
                     end else begin
                        state_ff <= S_F_HDR;
                     end
                  end
               end
            end
            S_A_HDR: begin
               if (fits) begin
                  blk_ff         <= bsz;
                  rm_ff          <= cur_ff;
                  caller_free_ff <= 1'b0;
                  state_ff       <= S_R_P;
               end else begin
                  state_ff <= S_A_NXT;
               end
            end
            S_A_NXT: begin
               steps_ff <= steps_n;
               cur_ff   <= rdata[AW-1:0];
               if (rdata[63] && steps_n < LIMIT_S) begin
                  state_ff <= S_A_HDR;
               end else begin
                  res_stat_ff <= bta_pkg::STAT_OOM;
                  state_ff    <= S_RESP;
               end
            end
            S_R_P: begin
               p_ff     <= rdata;
               state_ff <= S_R_N;
            end
            S_R_N: begin
               n_ff     <= rdata;
               state_ff <= S_R_W1;
            end
            S_R_W1: begin
               if (!p_ff[63]) begin
                  hv_ff   <= n_ff[63];
                  head_ff <= n_ff[63] ? n_ff[AW-1:0] : '0;
               end
               state_ff <= S_R_W2;
            end
            S_R_W2: state_ff <= S_R_W3;
            S_R_W3: state_ff <= S_R_W4;
            S_R_W4: begin
               if (caller_free_ff) begin
                  state_ff <= S_F_M1;
               end else begin
                  res_addr_ff <= user_addr;
                  res_stat_ff <= bta_pkg::STAT_OK;
                  state_ff    <= (left >= bta_pkg::MIN_BLK) ? S_A_S1 : S_A_W1;
               end
            end
            S_A_S1: state_ff <= S_A_S2;
            S_A_S2: state_ff <= S_A_S3;
            S_A_S3: state_ff <= S_A_S4;
            S_A_S4: state_ff <= S_A_S5;
            S_A_S5: state_ff <= S_A_S6;
            S_A_S6: begin
               psh_ff   <= rest[AW-1:0];
               state_ff <= S_P1;
            end
            S_A_W1: state_ff <= S_A_W2;
            S_A_W2: state_ff <= S_RESP;
            S_F_HDR: begin
               if (!rdata[0] || !size_ok(cur64, bsz)) begin
                  res_stat_ff <= bta_pkg::STAT_BAD;
                  state_ff    <= S_RESP;
               end else begin
                  blk_ff      <= bsz;
                  res_stat_ff <= bta_pkg::STAT_OK;
                  state_ff    <= S_F_PS1;
               end
            end
            S_F_PS1: state_ff <= S_F_PS2;
            S_F_PS2: begin
               psh_ff   <= cur_ff;
               state_ff <= (nxt < WORDS64) ? S_F_NHDR : S_P1;
            end
            S_F_NHDR: begin
               if (!rdata[0] && size_ok(nxt, bsz)) begin
                  nsz_ff         <= bsz;
                  rm_ff          <= nxt[AW-1:0];
                  caller_free_ff <= 1'b1;
                  state_ff       <= S_R_P;
               end else begin
                  state_ff <= S_P1;
               end
            end
            S_F_M1: state_ff <= S_F_M2;
            S_F_M2: begin
               psh_ff   <= cur_ff;
               state_ff <= S_P1;
            end
            S_P1: state_ff <= S_P2;
            S_P2: state_ff <= S_P3;
            S_P3: begin
               head_ff  <= psh_ff;
               hv_ff    <= 1'b1;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= res_addr_ff;
                  rsp_tuser_ff  <= res_stat_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != S_IDLE)
      else $error("accepted item left the sequencer idle");

   a_push_sets_head: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_P3 |=> hv_ff && head_ff == $past(psh_ff))
      else $error("free list head not updated by push");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE || state_ff == S_RESP |-> !mem_we)
      else $error("arena written outside of an operation");

endmodule

FILE: src/bta_ram.sv
// ----------------------------------------------------------------------------
// bta_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bta_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
